// ----- hdl/sit_pkg.sv -----
// Shared package of the sorted id table: action and status codes, sequencer
// states and the result record. Used by the channel interfaces and the top level.
// No dependencies.
package sit_pkg;

  localparam int ACTION_W    = 2;
  localparam int CMD_ID_W    = 16;
  localparam int OPT_BIT_W   = 5;
  localparam int READ_IDX_W  = 6;
  localparam int STATUS_W    = 3;
  localparam int ENTRY_IDX_W = 6;
  localparam int ENTRY_ID_W  = 16;
  localparam int ENTRY_MSK_W = 32;
  localparam int ENTRY_CNT_W = 7;

  typedef enum logic [ACTION_W-1:0] {
    ACT_CMD  = 2'd0,
    ACT_OPT  = 2'd1,
    ACT_READ = 2'd2,
    ACT_NONE = 2'd3
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_FOUND    = 3'd0,
    STAT_INSERTED = 3'd1,
    STAT_OPT_SET  = 3'd2,
    STAT_NO_CMD   = 3'd3,
    STAT_FULL     = 3'd4,
    STAT_READ_OK  = 3'd5,
    STAT_RANGE    = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PLACE,
    S_SHIFT,
    S_WRITE,
    S_OPT,
    S_READ,
    S_FIN
  } state_e;

  typedef struct packed {
    status_e                  status;
    logic [ENTRY_IDX_W-1:0]   entry_index;
    logic [ENTRY_ID_W-1:0]    entry_id;
    logic [ENTRY_MSK_W-1:0]   entry_mask;
    logic [ENTRY_CNT_W-1:0]   entry_count;
  } result_t;

endpackage

// ----- hdl/sit_req_if.sv -----
// Request channel of the sorted id table: valid/ready handshake and the
// request fields. Depends on sit_pkg.
interface sit_req_if;
  import sit_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [ACTION_W-1:0]   action;
  logic [CMD_ID_W-1:0]   cmd_id;
  logic [OPT_BIT_W-1:0]  option_bit;
  logic [READ_IDX_W-1:0] read_index;

  modport source (output valid, output action, output cmd_id, output option_bit,
                  output read_index, input ready);
  modport sink   (input valid, input action, input cmd_id, input option_bit,
                  input read_index, output ready);
endinterface

// ----- hdl/sit_rsp_if.sv -----
// Response channel of the sorted id table: valid/ready handshake and the
// response fields. Depends on sit_pkg.
interface sit_rsp_if;
  import sit_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [STATUS_W-1:0]    status;
  logic [ENTRY_IDX_W-1:0] entry_index;
  logic [ENTRY_ID_W-1:0]  entry_id;
  logic [ENTRY_MSK_W-1:0] entry_mask;
  logic [ENTRY_CNT_W-1:0] entry_count;

  modport source (output valid, output status, output entry_index, output entry_id,
                  output entry_mask, output entry_count, input ready);
  modport sink   (input valid, input status, input entry_index, input entry_id,
                  input entry_mask, input entry_count, output ready);
endinterface

// ----- hdl/sorted_id_table_with_option_masks.sv -----
// Top level of the sorted id table with option masks: sequencer, counters and
// result register. Depends on sit_pkg, sit_req_if, sit_rsp_if and sit_table_ram.
//
// Requests arrive on req_i and each one that does something gives exactly one
// response on rsp_o; both channels use valid/ready. The block takes one request
// at a time: req_i.ready is high only while the sequencer is idle.
// A command request scans the table one entry per cycle through the single
// read port of the entry RAM until it meets an id not below its own. If the id
// is absent, later entries move up one place per cycle, then the new entry is
// written. A found command goes from the scan straight to the finish state; an
// absent one passes through the place state and, unless the table is full, any
// shifting and the write state. Option and read requests pass through the option
// or read state before finishing; an early error answer goes straight to finish.
// The response sits in an output register; while the receiver stalls, the next
// request can still be accepted and worked on, and the finished response waits
// in a staging register until the output register frees up.
// Reset empties the table and clears the current entry; RAM contents are not
// cleared, since data read from positions at or above the entry count is never used.
module sorted_id_table_with_option_masks #(
  parameter int CAPACITY  = 64,
  parameter int ID_BITS   = 16,
  parameter int MASK_BITS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  sit_req_if.sink   req_i,
  sit_rsp_if.source rsp_o
);
  import sit_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int KW = (ID_BITS < CMD_ID_W) ? ID_BITS : CMD_ID_W;
  localparam int MW = MASK_BITS;

  function automatic logic [ENTRY_IDX_W-1:0] to_idx(input logic [IW-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[ENTRY_IDX_W-1:0];
  endfunction

  function automatic logic [ENTRY_CNT_W-1:0] to_cnt(input logic [CW-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[ENTRY_CNT_W-1:0];
  endfunction

  function automatic logic [ENTRY_MSK_W-1:0] to_msk(input logic [MW-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[ENTRY_MSK_W-1:0];
  endfunction

  state_e               state_q, state_d;
  logic [KW-1:0]        key_q, key_d;
  logic [OPT_BIT_W-1:0] bit_q, bit_d;
  logic [READ_IDX_W-1:0] ridx_q, ridx_d;
  logic [IW-1:0]        ptr_q, ptr_d;
  logic [IW-1:0]        pos_q, pos_d;
  logic [IW-1:0]        sh_q, sh_d;
  logic [CW-1:0]        used_q, used_d;
  logic [IW-1:0]        cur_pos_q, cur_pos_d;
  logic                 cur_valid_q, cur_valid_d;
  result_t              res_q, res_d;
  result_t              out_q, out_d;
  logic                 out_valid_q, out_valid_d;

  logic                 we;
  logic [IW-1:0]        waddr;
  logic [KW-1:0]        wid;
  logic [MW-1:0]        wmask;
  logic [IW-1:0]        raddr;
  logic [KW-1:0]        rid;
  logic [MW-1:0]        rmask;
  logic [MW-1:0]        set_mask;
  logic [CW-1:0]        ptr_next;

  sit_table_ram #(
    .DEPTH (CAPACITY),
    .AW    (IW),
    .IDW   (KW),
    .MSW   (MW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wid_i   (wid),
    .wmask_i (wmask),
    .raddr_i (raddr),
    .rid_o   (rid),
    .rmask_o (rmask)
  );

  assign set_mask = (32'(bit_q) < 32'(MW)) ? (MW'(1) << bit_q) : '0;
  assign ptr_next = CW'(ptr_q) + CW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      cur_pos_q   <= '0;
      cur_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      cur_pos_q   <= cur_pos_d;
      cur_valid_q <= cur_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    bit_q  <= bit_d;
    ridx_q <= ridx_d;
    ptr_q  <= ptr_d;
    pos_q  <= pos_d;
    sh_q   <= sh_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  always_comb begin
    state_d     = state_q;
    key_d       = key_q;
    bit_d       = bit_q;
    ridx_d      = ridx_q;
    ptr_d       = ptr_q;
    pos_d       = pos_q;
    sh_d        = sh_q;
    used_d      = used_q;
    cur_pos_d   = cur_pos_q;
    cur_valid_d = cur_valid_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    we          = 1'b0;
    waddr       = sh_q;
    wid         = rid;
    wmask       = rmask;
    raddr       = ptr_q;
    req_i.ready = (state_q == S_IDLE);

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          key_d  = req_i.cmd_id[KW-1:0];
          bit_d  = req_i.option_bit;
          ridx_d = req_i.read_index;
          case (action_e'(req_i.action))
            ACT_CMD: begin
              ptr_d = '0;
              raddr = '0;
              pos_d = '0;
              state_d = (used_q == '0) ? S_PLACE : S_SCAN;
            end
            ACT_OPT: begin
              raddr = cur_pos_q;
              if (cur_valid_q) begin
                state_d = S_OPT;
              end else begin
                res_d = '{STAT_NO_CMD, '0, '0, '0, to_cnt(used_q)};
                state_d = S_FIN;
              end
            end
            ACT_READ: begin
              raddr = IW'(req_i.read_index);
              if (32'(req_i.read_index) < 32'(used_q)) begin
                state_d = S_READ;
              end else begin
                res_d = '{STAT_RANGE, req_i.read_index, '0, '0, to_cnt(used_q)};
                state_d = S_FIN;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (rid == key_q) begin
          cur_pos_d   = ptr_q;
          cur_valid_d = 1'b1;
          res_d = '{STAT_FOUND, to_idx(ptr_q), ENTRY_ID_W'(rid), to_msk(rmask),
                    to_cnt(used_q)};
          state_d = S_FIN;
        end else if (rid > key_q) begin
          pos_d   = ptr_q;
          state_d = S_PLACE;
        end else if (ptr_next == used_q) begin
          pos_d   = IW'(ptr_next);
          state_d = S_PLACE;
        end else begin
          ptr_d = IW'(ptr_next);
          raddr = IW'(ptr_next);
        end
      end
      S_PLACE: begin
        if (used_q == CW'(CAPACITY)) begin
          cur_valid_d = 1'b0;
          res_d = '{STAT_FULL, '0, ENTRY_ID_W'(key_q), '0, to_cnt(used_q)};
          state_d = S_FIN;
        end else if (CW'(pos_q) == used_q) begin
          state_d = S_WRITE;
        end else begin
          sh_d    = IW'(used_q);
          raddr   = IW'(used_q) - IW'(1);
          state_d = S_SHIFT;
        end
      end
      S_SHIFT: begin
        we    = 1'b1;
        waddr = sh_q;
        sh_d  = sh_q - IW'(1);
        if (sh_q - IW'(1) == pos_q) begin
          state_d = S_WRITE;
        end else begin
          raddr = sh_q - IW'(2);
        end
      end
      S_WRITE: begin
        we          = 1'b1;
        waddr       = pos_q;
        wid         = key_q;
        wmask       = '0;
        used_d      = used_q + CW'(1);
        cur_pos_d   = pos_q;
        cur_valid_d = 1'b1;
        res_d = '{STAT_INSERTED, to_idx(pos_q), ENTRY_ID_W'(key_q), '0,
                  to_cnt(used_q + CW'(1))};
        state_d = S_FIN;
      end
      S_OPT: begin
        we    = 1'b1;
        waddr = cur_pos_q;
        wmask = rmask | set_mask;
        res_d = '{STAT_OPT_SET, to_idx(cur_pos_q), ENTRY_ID_W'(rid),
                  to_msk(rmask | set_mask), to_cnt(used_q)};
        state_d = S_FIN;
      end
      S_READ: begin
        res_d = '{STAT_READ_OK, ridx_q, ENTRY_ID_W'(rid), to_msk(rmask),
                  to_cnt(used_q)};
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_q.status;
  assign rsp_o.entry_index = out_q.entry_index;
  assign rsp_o.entry_id    = out_q.entry_id;
  assign rsp_o.entry_mask  = out_q.entry_mask;
  assign rsp_o.entry_count = out_q.entry_count;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(used_q) <= CAPACITY)
    else $error("entry count exceeds capacity");

  a_current_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q |-> (CW'(cur_pos_q) < used_q))
    else $error("current entry lies outside the table");

  a_shift_above_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT) |-> (sh_q > pos_q))
    else $error("shift pointer passed the insertion slot");

  a_insert_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRITE) |=> (used_q == $past(used_q) + CW'(1)))
    else $error("insertion did not grow the table by one");
`endif

endmodule

// ----- hdl/sit_table_ram.sv -----
// Entry storage of the sorted id table: id and mask arrays with one write
// port and one registered read port sharing its address. No dependencies.
module sit_table_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int IDW   = 16,
  parameter int MSW   = 32
) (
  input  logic           clk_i,
  input  logic           we_i,
  input  logic [AW-1:0]  waddr_i,
  input  logic [IDW-1:0] wid_i,
  input  logic [MSW-1:0] wmask_i,
  input  logic [AW-1:0]  raddr_i,
  output logic [IDW-1:0] rid_o,
  output logic [MSW-1:0] rmask_o
);

  logic [IDW-1:0] id_mem   [DEPTH];
  logic [MSW-1:0] mask_mem [DEPTH];
  logic [IDW-1:0] rid_q;
  logic [MSW-1:0] rmask_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      id_mem[waddr_i]   <= wid_i;
      mask_mem[waddr_i] <= wmask_i;
    end
    rid_q   <= id_mem[raddr_i];
    rmask_q <= mask_mem[raddr_i];
  end

  assign rid_o   = rid_q;
  assign rmask_o = rmask_q;

endmodule
